/* sv/chn_pkg.sv */
package chn_pkg;

  localparam int NUM_BINS   = 128;
  localparam int COUNT_BITS = 16;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int MAP_DEPTH  = 256;
  localparam int SUM_W      = 40;
  localparam int INV_W      = 32;
  localparam int PROD_W     = COUNT_BITS + INV_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [SUM_W-1:0]      SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [7:0]            MAP_NONE  = 8'hFF;
  localparam logic [15:0]           Q15_ONE   = 16'd32768;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_UNK_EN  = 1'b0,
    REG_UNK_BIN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       byte_value;
    logic signed [7:0] map_bin;
    logic             last_byte;
    logic [6:0]       read_index;
  } in_req_t;

  typedef struct packed {
    logic [15:0] normalized_value;
    logic [15:0] raw_count;
    logic        norm_ready;
  } out_req_t;

endpackage

/* sv/chn_map_mem.sv */
module chn_map_mem
  import chn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic [7:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0]           mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] valid_r;
  logic [7:0]           rdata_r;
  logic                 rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // entries never loaded read as unmapped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : MAP_NONE;

endmodule

/* sv/chn_count_mem.sv */
module chn_count_mem
  import chn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clear,
  input  logic                  we,
  input  logic [BIN_W-1:0]      waddr,
  input  logic [COUNT_BITS-1:0] wdata,
  input  logic [BIN_W-1:0]      raddr,
  output logic [COUNT_BITS-1:0] rdata
);

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]   valid_r;
  logic [COUNT_BITS-1:0] rdata_r;
  logic                  rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // clear drops every bin to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (clear) begin
        valid_r <= '0;
      end else if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

/* sv/chn_inv_norm.sv */
module chn_inv_norm
  import chn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] sum,
  output logic             done,
  output logic [INV_W-1:0] inv
);

  typedef enum logic [1:0] {
    N_IDLE,
    N_DIV,
    N_SQRT
  } nstate_t;

  nstate_t          state_r;
  logic [5:0]       cnt_r;
  logic [SUM_W-1:0] div_r;
  logic [SUM_W:0]   rem_r;
  logic [62:0]      quo_r;
  logic [62:0]      bit_r;
  logic [63:0]      root_r;
  logic             done_r;
  logic [INV_W-1:0] inv_r;

  logic [SUM_W:0] rem_sh;
  logic           rem_ge;
  logic [63:0]    trial;
  logic           sq_ge;

  // restoring divide of 2^62 by sum, one quotient bit per cycle
  assign rem_sh = {rem_r[SUM_W-1:0], (cnt_r == 6'd62)};
  assign rem_ge = rem_sh >= {1'b0, div_r};
  // digit-by-digit square root of the quotient, one result bit per cycle
  assign trial  = root_r + {1'b0, bit_r};
  assign sq_ge  = {1'b0, quo_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            div_r   <= sum;
            rem_r   <= '0;
            quo_r   <= '0;
            cnt_r   <= 6'd62;
            state_r <= N_DIV;
          end
        end
        N_DIV: begin
          rem_r <= rem_ge ? rem_sh - {1'b0, div_r} : rem_sh;
          quo_r <= {quo_r[61:0], rem_ge};
          if (cnt_r == 6'd0) begin
            bit_r   <= 63'd1 << 62;
            root_r  <= '0;
            state_r <= N_SQRT;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        N_SQRT: begin
          if (sq_ge) begin
            quo_r  <= quo_r - trial[62:0];
            root_r <= (root_r >> 1) + {1'b0, bit_r};
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            done_r  <= 1'b1;
            state_r <= N_IDLE;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == N_SQRT && bit_r[0]) begin
      inv_r <= sq_ge ? INV_W'((root_r >> 1) + {1'b0, bit_r}) : INV_W'(root_r >> 1);
    end
  end

  assign done = done_r;
  assign inv  = inv_r;

endmodule

/* sv/char_histogram_l2_normalizer_unit.sv */
// Bag-of-characters histogram with L2 normalization. Requests: load a byte's
// bin mapping (command 0), count a text byte (command 1), read a bin (command
// 2, the only request that returns a result). Map and bin counts live in
// synchronous RAMs; a count runs through map read, bin read, write-back and
// finish, skipping bin read and write-back when the byte is dropped; a load
// is taken in idle; a read runs a multiply step, then an output step that
// waits on output backpressure. A byte marked last_byte runs the
// inverse-norm unit, a bit-serial divide and then a bit-serial square root,
// unless the sum is zero. The first count after a finished text clears the
// histogram in the same cycle. The result register lets a new request in
// while a read result waits. Configuration must be written only while idle.
module char_histogram_l2_normalizer_unit
  import chn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [6:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_RD,
    ST_BIN_RD,
    ST_FIN,
    ST_NORM,
    ST_RD_MUL,
    ST_RD_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   rd_ok_r, rd_ok_nxt;
  logic   tf_r, tf_nxt;
  logic   out_valid_r, out_valid_nxt;
  out_req_t out_data_r, out_data_nxt;
  logic [BIN_W-1:0]      bin_r, bin_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [INV_W-1:0]      inv_r, inv_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [COUNT_BITS-1:0] hold_r, hold_nxt;
  logic       unk_en_r;
  logic [6:0] unk_bin_r;

  logic                  map_we;
  logic [7:0]            map_rdata;
  logic                  cnt_clear, cnt_we;
  logic [BIN_W-1:0]      cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  norm_start, norm_done;
  logic [INV_W-1:0]      norm_inv;

  logic                  hit;
  logic [6:0]            bin7;
  logic [SUM_W:0]        sum_add;
  logic [PROD_W-16-1:0]  norm_full;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign map_we    = in_valid && in_ready && (in_data.command == CMD_LOAD);

  chn_map_mem u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (map_we),
    .waddr (in_data.byte_value),
    .wdata (in_data.map_bin),
    .raddr (in_data.byte_value),
    .rdata (map_rdata)
  );

  chn_count_mem u_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (cnt_clear),
    .we    (cnt_we),
    .waddr (bin_r),
    .wdata (cnt_rdata + COUNT_BITS'(1)),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  chn_inv_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .sum   (sum_r),
    .done  (norm_done),
    .inv   (norm_inv)
  );

  // mapped byte goes to its bin, unmapped one to the unknown bin if enabled
  assign hit  = !map_rdata[7] || unk_en_r;
  assign bin7 = map_rdata[7] ? unk_bin_r : map_rdata[6:0];
  // count c -> c+1 adds 2c+1 to the sum of squares
  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'({cnt_rdata, 1'b1});
  assign norm_full = prod_r[PROD_W-1:16];

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    rd_ok_nxt     = rd_ok_r;
    tf_nxt        = tf_r;
    bin_nxt       = bin_r;
    sum_nxt       = sum_r;
    inv_nxt       = inv_r;
    prod_nxt      = prod_r;
    hold_nxt      = hold_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cnt_clear     = 1'b0;
    cnt_we        = 1'b0;
    cnt_raddr     = BIN_W'(in_data.read_index);
    norm_start    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.command)
            CMD_COUNT: begin
              last_nxt = in_data.last_byte;
              if (tf_r) begin
                // new text: start from an empty histogram
                cnt_clear = 1'b1;
                sum_nxt   = '0;
                inv_nxt   = '0;
                tf_nxt    = 1'b0;
              end
              state_nxt = ST_MAP_RD;
            end
            CMD_READ: begin
              rd_ok_nxt = ({2'b00, in_data.read_index} < 9'(NUM_BINS));
              state_nxt = ST_RD_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_MAP_RD: begin
        if (hit && ({2'b00, bin7} < 9'(NUM_BINS))) begin
          cnt_raddr = BIN_W'(bin7);
          bin_nxt   = BIN_W'(bin7);
          state_nxt = ST_BIN_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_BIN_RD: begin
        if (cnt_rdata != COUNT_MAX) begin
          cnt_we  = 1'b1;
          sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (sum_r == '0) begin
          inv_nxt   = '0;
          tf_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          norm_start = 1'b1;
          state_nxt  = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          inv_nxt   = norm_inv;
          tf_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_MUL: begin
        hold_nxt  = rd_ok_r ? cnt_rdata : '0;
        prod_nxt  = rd_ok_r ? PROD_W'(cnt_rdata) * PROD_W'(inv_r) : '0;
        state_nxt = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.normalized_value = (norm_full > (PROD_W-16)'(Q15_ONE)) ?
                                          Q15_ONE : norm_full[15:0];
          out_data_nxt.raw_count = ((COUNT_BITS+1)'(hold_r) > 17'hFFFF) ?
                                   16'hFFFF : 16'(hold_r);
          out_data_nxt.norm_ready = tf_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tf_r        <= 1'b0;
      sum_r       <= '0;
      inv_r       <= '0;
      out_valid_r <= 1'b0;
      unk_en_r    <= 1'b0;
      unk_bin_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      tf_r        <= tf_nxt;
      sum_r       <= sum_nxt;
      inv_r       <= inv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_UNK_EN:  unk_en_r  <= cfg_wdata[0];
          REG_UNK_BIN: unk_bin_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    rd_ok_r    <= rd_ok_nxt;
    bin_r      <= bin_nxt;
    prod_r     <= prod_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_norm_done_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> state_r == ST_NORM) else $error("norm done outside wait");
  a_tf_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(tf_r) |-> ($past(state_r) == ST_FIN || $past(state_r) == ST_NORM))
    else $error("text finished set outside end of text");
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RD_OUT)
    else $error("result without read");
  a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
    inv_r <= 32'h8000_0000) else $error("inverse norm above one");
`endif

endmodule
